[sv/centered_moving_average_defines.svh]
`ifndef CENTERED_MOVING_AVERAGE_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DEFINES_SVH

// Implication checked every clock edge, ignored while reset is high.
`define CMA_ASSERT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is high.
`define CMA_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/cma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  localparam int MAX_DEPTH    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int TIME_BITS    = 48;
  localparam int DEPTH_BITS   = $clog2(MAX_DEPTH) + 1;
  localparam int PTR_BITS     = $clog2(MAX_DEPTH);
  localparam int SCALE_BITS   = 17;
  localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
  localparam int PROD_BITS    = SUM_BITS + SCALE_BITS + 1;
  localparam int FRAC_BITS    = 16;
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;
  localparam int REG_IDX_BITS = PADDR_BITS - 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]          time_t;
  typedef logic [DEPTH_BITS-1:0]         depth_t;
  typedef logic [PTR_BITS-1:0]           ptr_t;
  typedef logic [SCALE_BITS-1:0]         scale_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [REG_IDX_BITS-1:0]       reg_idx_t;

  localparam reg_idx_t REG_WINDOW_DEPTH     = reg_idx_t'(0);
  localparam reg_idx_t REG_RECIPROCAL_SCALE = reg_idx_t'(1);

  localparam depth_t DEPTH_RESET = depth_t'(10);
  localparam scale_t SCALE_RESET = scale_t'(6554);

  // Working configuration seen by the datapath.
  typedef struct packed {
    depth_t eff_depth;
    scale_t scale;
    logic   restart;
  } cfg_t;

  // One item between the delay-line stage and the arithmetic stages.
  typedef struct packed {
    sample_t sample;
    sample_t old_sample;
    logic    sub;
    logic    full;
    logic    last;
    time_t   centre_time;
    time_t   centre_duration;
  } s1_item_t;

endpackage

`default_nettype wire

[sv/cma_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cma_in_if;
  import cma_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  time_t   timestamp;
  time_t   duration;
  logic    record_end;

  modport source (output valid, output sample, output timestamp, output duration,
                  output record_end, input ready);
  modport sink (input valid, input sample, input timestamp, input duration,
                input record_end, output ready);
endinterface

`default_nettype wire

[sv/cma_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cma_out_if;
  import cma_pkg::*;

  logic    valid;
  logic    ready;
  sample_t average;
  time_t   centre_time;
  time_t   centre_duration;
  logic    final_result;
  logic    too_short;

  modport source (output valid, output average, output centre_time,
                  output centre_duration, output final_result, output too_short,
                  input ready);
  modport sink (input valid, input average, input centre_time, input centre_duration,
                input final_result, input too_short, output ready);
endinterface

`default_nettype wire

[sv/cma_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module cma_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cma_pkg::PADDR_BITS-1:0] paddr,
  input  logic [cma_pkg::PDATA_BITS-1:0] pwdata,
  output logic [cma_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  output cma_pkg::cfg_t                  cfg
);
  import cma_pkg::*;

  depth_t   window_depth;
  scale_t   reciprocal_scale;
  depth_t   eff_depth;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_depth     <= DEPTH_RESET;
      reciprocal_scale <= SCALE_RESET;
    end else if (wr) begin
      case (idx)
        REG_WINDOW_DEPTH:     window_depth     <= pwdata[DEPTH_BITS-1:0];
        REG_RECIPROCAL_SCALE: reciprocal_scale <= pwdata[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW_DEPTH:     prdata = PDATA_BITS'(window_depth);
      REG_RECIPROCAL_SCALE: prdata = PDATA_BITS'(reciprocal_scale);
      default:              prdata = '0;
    endcase
  end

  // A depth of zero behaves as one; anything beyond the delay lines is clipped.
  always_comb begin
    if (window_depth == '0) begin
      eff_depth = depth_t'(1);
    end else if (window_depth > depth_t'(MAX_DEPTH)) begin
      eff_depth = depth_t'(MAX_DEPTH);
    end else begin
      eff_depth = window_depth;
    end
  end

  assign cfg.eff_depth = eff_depth;
  assign cfg.scale     = reciprocal_scale;
  assign cfg.restart   = wr && (idx == REG_WINDOW_DEPTH);

endmodule

`default_nettype wire

[sv/cma_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cma_front (
  input  logic               clk,
  input  logic               rst,
  cma_in_if.sink             in_ch,
  input  cma_pkg::cfg_t      cfg,
  input  logic               s1_take,
  output logic               s1_valid,
  output cma_pkg::s1_item_t  s1_item
);
  import cma_pkg::*;

  sample_t sample_mem [MAX_DEPTH];
  time_t   time_mem [MAX_DEPTH];
  time_t   dur_mem [MAX_DEPTH];

  ptr_t    write_pointer;
  depth_t  samples_seen;
  logic    accept;
  ptr_t    d_lo;
  ptr_t    d_half;
  ptr_t    old_ptr;
  ptr_t    centre_ptr;
  logic [DEPTH_BITS:0] seen_inc;
  logic    sub_now;
  logic    full_now;

  sample_t old_rd;
  time_t   time_rd;
  time_t   dur_rd;
  sample_t sample_q;
  time_t   ts_q;
  time_t   du_q;
  logic    sub_q;
  logic    full_q;
  logic    last_q;
  logic    bypass_q;

  assign in_ch.ready = !s1_valid || s1_take;
  assign accept      = in_ch.valid && in_ch.ready;

  assign d_lo       = cfg.eff_depth[PTR_BITS-1:0];
  assign d_half     = PTR_BITS'(cfg.eff_depth >> 1);
  assign old_ptr    = write_pointer - d_lo;
  assign centre_ptr = write_pointer + ptr_t'(1) + d_half - d_lo;
  assign seen_inc   = {1'b0, samples_seen} + (DEPTH_BITS + 1)'(1);
  assign sub_now    = samples_seen >= cfg.eff_depth;
  assign full_now   = seen_inc >= {1'b0, cfg.eff_depth};

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      write_pointer <= '0;
      samples_seen  <= '0;
    end else if (accept) begin
      if (in_ch.record_end) begin
        write_pointer <= '0;
        samples_seen  <= '0;
      end else begin
        write_pointer <= write_pointer + ptr_t'(1);
        samples_seen  <= full_now ? cfg.eff_depth : seen_inc[DEPTH_BITS-1:0];
      end
    end
  end

  // Read-first memories: at full depth the oldest entry shares the write
  // address and must come out before it is overwritten.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_mem[write_pointer] <= in_ch.sample;
      old_rd                    <= sample_mem[old_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_mem[write_pointer] <= in_ch.timestamp;
      time_rd                 <= time_mem[centre_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dur_mem[write_pointer] <= in_ch.duration;
      dur_rd                 <= dur_mem[centre_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= in_ch.sample;
      ts_q     <= in_ch.timestamp;
      du_q     <= in_ch.duration;
      sub_q    <= sub_now;
      full_q   <= full_now;
      last_q   <= in_ch.record_end;
      bypass_q <= centre_ptr == write_pointer;
    end
  end

  // For depths of one and two the centre sample is the one just arriving.
  assign s1_item.sample          = sample_q;
  assign s1_item.old_sample      = old_rd;
  assign s1_item.sub             = sub_q;
  assign s1_item.full            = full_q;
  assign s1_item.last            = last_q;
  assign s1_item.centre_time     = bypass_q ? ts_q : time_rd;
  assign s1_item.centre_duration = bypass_q ? du_q : dur_rd;

endmodule

`default_nettype wire

[sv/cma_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cma_back (
  input  logic               clk,
  input  logic               rst,
  input  cma_pkg::cfg_t      cfg,
  input  logic               s1_valid,
  input  cma_pkg::s1_item_t  s1_item,
  output logic               s1_take,
  cma_out_if.source          out_ch
);
  import cma_pkg::*;

  localparam int Q_BITS = PROD_BITS - FRAC_BITS;

  sum_t    window_sum;
  sum_t    sum_upd;
  sum_t    old_term;

  logic    s2_valid;
  sum_t    s2_sum;
  logic    s2_full;
  logic    s2_last;
  time_t   s2_time;
  time_t   s2_dur;

  logic    s2_has_res;
  logic    out_free;
  logic    out_load;
  logic    s2_free;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [Q_BITS-1:0]    q;
  sample_t                     avg_sat;

  assign old_term = s1_item.sub ? SUM_BITS'(s1_item.old_sample) : '0;
  assign sum_upd  = window_sum + SUM_BITS'(s1_item.sample) - old_term;

  assign s2_has_res = s2_full || s2_last;
  assign out_free   = !out_ch.valid || out_ch.ready;
  assign out_load   = s2_valid && s2_has_res && out_free;
  assign s2_free    = !s2_valid || !s2_has_res || out_free;
  assign s1_take    = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      window_sum <= '0;
    end else if (s1_take) begin
      window_sum <= s1_item.last ? '0 : sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take) begin
      s2_valid <= 1'b1;
    end else if (s2_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_sum  <= sum_upd;
      s2_full <= s1_item.full;
      s2_last <= s1_item.last;
      s2_time <= s1_item.centre_time;
      s2_dur  <= s1_item.centre_duration;
    end
  end

  // Floor division by 2^16 is the arithmetic shift; saturate when the upper
  // bits are not a copy of the result's sign.
  assign prod = s2_sum * $signed({1'b0, cfg.scale});
  assign q    = prod[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    if (q[Q_BITS-1:SAMPLE_BITS-1] == '0 || q[Q_BITS-1:SAMPLE_BITS-1] == '1) begin
      avg_sat = q[SAMPLE_BITS-1:0];
    end else if (q[Q_BITS-1]) begin
      avg_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      avg_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.average         <= s2_full ? avg_sat : '0;
      out_ch.centre_time     <= s2_full ? s2_time : '0;
      out_ch.centre_duration <= s2_full ? s2_dur : '0;
      out_ch.final_result    <= s2_last;
      out_ch.too_short       <= !s2_full;
    end
  end

endmodule

`default_nettype wire

[sv/centered_moving_average.sv]
`timescale 1ns / 1ps
`default_nettype none

// Centred boxcar average over a stream of record samples. One sample is taken
// per clock cycle while the output is not stalled, and each result passes
// three registered stages: the edge that accepts its sample captures the
// delay-line memory read, the stage-two register the running-sum update and
// the output register the reciprocal multiply and saturation. The rate of
// one item per cycle is set by the single write and single registered read
// port of each 1024-entry delay line. A result held by a stalled receiver
// holds the input off once all three stages are occupied. Once a full
// window is held every sample yields a result carrying the average and the
// timing of the window's centre sample; a record that ends before its window
// fills gives one result marked too_short. The delay lines need no clearing
// after reset, since only entries of the current record are read. Writing
// window_depth restarts the record and should be done only while idle.
module centered_moving_average (
  input  logic                           clk,
  input  logic                           rst,
  cma_in_if.sink                         in_ch,
  cma_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cma_pkg::PADDR_BITS-1:0] paddr,
  input  logic [cma_pkg::PDATA_BITS-1:0] pwdata,
  output logic [cma_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import cma_pkg::*;

  cfg_t     cfg;
  logic     s1_valid;
  logic     s1_take;
  s1_item_t s1_item;

  cma_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cma_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cma_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[sv/cma_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "centered_moving_average_defines.svh"

module cma_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [15:0]             average,
  input logic [47:0]             centre_time,
  input logic [47:0]             centre_duration,
  input logic                    final_result,
  input logic                    too_short
);

  `CMA_ASSERT_NEXT(a_reset_clears_out, clk, rst, !out_valid, "result valid after reset")

  `CMA_ASSERT(a_out_holds, clk, rst, out_valid && !out_ready, ##1 (out_valid && $stable(average) && $stable(centre_time) && $stable(final_result)), "stalled result changed")

  `CMA_ASSERT(a_short_is_final, clk, rst, out_valid && too_short, final_result && average == 16'd0, "short record result malformed")

  `CMA_ASSERT(a_short_no_timing, clk, rst, out_valid && too_short, centre_time == 48'd0 && centre_duration == 48'd0, "short record carries timing")

endmodule

bind centered_moving_average cma_checker u_cma_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .average         (out_ch.average),
  .centre_time     (out_ch.centre_time),
  .centre_duration (out_ch.centre_duration),
  .final_result    (out_ch.final_result),
  .too_short       (out_ch.too_short)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cma_pkg::*;

  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    DRAIN_LIMIT   = 20000;
  localparam int    SETTLE_CYCLES = 10;
  localparam int    HOLD_CYCLES   = 300;
  localparam time_t TIME_ALL_ONES = {TIME_BITS{1'b1}};
  localparam sample_t SAMPLE_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t average;
    time_t   centre_time;
    time_t   centre_duration;
    logic    final_result;
    logic    too_short;
  } average_result_t;

  // Keeps its own copy of the window and the registers, and queues the result
  // that each accepted sample should produce, if it produces one.
  class window_average_tracker;
    sample_t         hist_sample [MAX_DEPTH];
    time_t           hist_time [MAX_DEPTH];
    time_t           hist_duration [MAX_DEPTH];
    longint          win_sum;
    int unsigned     seen;
    int unsigned     wr_ptr;
    depth_t          depth_reg;
    scale_t          scale_reg;
    average_result_t expected_averages [$];
    int unsigned     mismatches;

    function new();
      depth_reg  = DEPTH_RESET;
      scale_reg  = SCALE_RESET;
      mismatches = 0;
      restart_record();
    endfunction

    function void restart_record();
      win_sum = 0;
      seen    = 0;
      wr_ptr  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_BITS-1:0] value);
      case (idx)
        REG_WINDOW_DEPTH: begin
          depth_reg = value[DEPTH_BITS-1:0];
          restart_record();
        end
        REG_RECIPROCAL_SCALE: begin
          scale_reg = value[SCALE_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_sample(sample_t s, time_t ts, time_t du, logic last);
      int unsigned     d;
      int unsigned     wp;
      int unsigned     c;
      longint          q;
      average_result_t r;
      if (depth_reg == 0) d = 1;
      else if (depth_reg > MAX_DEPTH) d = MAX_DEPTH;
      else d = depth_reg;
      wp = wr_ptr;
      if (seen >= d) win_sum -= longint'(hist_sample[(wp + MAX_DEPTH - d) % MAX_DEPTH]);
      hist_sample[wp]   = s;
      hist_time[wp]     = ts;
      hist_duration[wp] = du;
      win_sum += longint'(s);
      if (seen < d) seen++;
      r = '0;
      if (seen >= d) begin
        c = (wp + MAX_DEPTH - d + 1 + d / 2) % MAX_DEPTH;
        // Arithmetic shift of the signed product gives the floor.
        q = (win_sum * longint'(scale_reg)) >>> FRAC_BITS;
        if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
        r.average         = sample_t'(q);
        r.centre_time     = hist_time[c];
        r.centre_duration = hist_duration[c];
        r.final_result    = last;
        expected_averages.push_back(r);
      end else if (last) begin
        r.final_result = 1'b1;
        r.too_short    = 1'b1;
        expected_averages.push_back(r);
      end
      wr_ptr = (wp + 1) % MAX_DEPTH;
      if (last) restart_record();
    endfunction

    function void note_mismatch(string what, average_result_t exp_r, average_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $realtime, what);
        $display("  expected avg %0d time %h dur %h final %b short %b",
                 $signed(exp_r.average), exp_r.centre_time, exp_r.centre_duration,
                 exp_r.final_result, exp_r.too_short);
        $display("  actual   avg %0d time %h dur %h final %b short %b",
                 $signed(got.average), got.centre_time, got.centre_duration,
                 got.final_result, got.too_short);
      end
    endfunction

    function void check_average(average_result_t got);
      average_result_t exp_r;
      if (expected_averages.size() == 0) begin
        note_mismatch("result with no sample waiting for it", '0, got);
        return;
      end
      exp_r = expected_averages.pop_front();
      if (got.average !== exp_r.average || got.centre_time !== exp_r.centre_time ||
          got.centre_duration !== exp_r.centre_duration ||
          got.final_result !== exp_r.final_result || got.too_short !== exp_r.too_short)
        note_mismatch("result fields differ", exp_r, got);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  cma_in_if  in_ch();
  cma_out_if out_ch();

  window_average_tracker tracker;
  int unsigned burst_left   = 0;
  int unsigned idle_gap     = 0;
  bit          offering     = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned rand_items   = 0;

  centered_moving_average dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    average_result_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_sample(in_ch.sample, in_ch.timestamp, in_ch.duration, in_ch.record_end);
      if (out_ch.valid && out_ch.ready) begin
        got.average         = out_ch.average;
        got.centre_time     = out_ch.centre_time;
        got.centre_duration = out_ch.centre_duration;
        got.final_result    = out_ch.final_result;
        got.too_short       = out_ch.too_short;
        tracker.check_average(got);
      end
    end
  end

  // The receiver switches between stall patterns of random length, and holds
  // off completely for a long stretch when asked to.
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    int unsigned hold;
    mode = 0;
    left = 0;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (left % 4 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic time_t rand_stamp();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return TIME_ALL_ONES;
      default: return time_t'({$urandom, $urandom});
    endcase
  endfunction

  // Offers one sample and returns at the edge where the transaction is taken.
  // The burst and gap bookkeeping decides there whether valid drops.
  task automatic send_sample(sample_t s, time_t ts, time_t du, logic last);
    repeat (idle_gap) @(posedge clk);
    idle_gap = 0;
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.timestamp  <= ts;
    in_ch.duration   <= du;
    in_ch.record_end <= last;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      idle_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (idle_gap != 0) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
      end
    end
  endtask

  task automatic send_record(int unsigned len, bit with_end);
    for (int unsigned i = 0; i < len; i++)
      send_sample(rand_sample(), rand_stamp(), rand_stamp(), with_end && (i == len - 1));
  endtask

  task automatic wait_idle();
    int unsigned waited = 0;
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (tracker.expected_averages.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Samples that cause no result may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves psel and penable high after the access phase, so that a following
  // write goes straight into its setup phase; apb_release ends the sequence.
  task automatic write_reg(reg_idx_t idx, logic [PDATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(depth_t depth_val, scale_t scale_val, int unsigned budget,
                           bit leave_open);
    int unsigned d;
    int unsigned len;
    int unsigned sent;
    if (depth_val == 0) d = 1;
    else if (depth_val > MAX_DEPTH) d = MAX_DEPTH;
    else d = depth_val;
    sent = 0;
    wait_idle();
    write_reg(REG_WINDOW_DEPTH, PDATA_BITS'(depth_val));
    write_reg(REG_RECIPROCAL_SCALE, PDATA_BITS'(scale_val));
    apb_release();
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0, 1: len = (d > 1) ? $urandom_range(1, d - 1) : 1;
        2: len = d;
        default: len = $urandom_range(d, 3 * d + 8);
      endcase
      send_record(len, !(leave_open && sent + len >= budget));
      sent += len;
    end
    rand_items += sent;
  endtask

  initial begin : stimulus
    int unsigned d;
    tracker = new();
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.timestamp  = '0;
    in_ch.duration   = '0;
    in_ch.record_end = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: a record too short for the window, then windows
    // saturating high and low with extreme timing values.
    for (int i = 0; i < 3; i++)
      send_sample(sample_t'(i - 1), time_t'(i), time_t'(i), i == 2);
    for (int i = 0; i < 11; i++)
      send_sample(SAMPLE_MAX, TIME_ALL_ONES - time_t'(i), time_t'(i), i == 10);
    for (int i = 0; i < 11; i++)
      send_sample(SAMPLE_MIN, time_t'(i), TIME_ALL_ONES - time_t'(i), i == 10);

    run_phase(depth_t'(1), scale_t'(65536), 40, 1'b0);
    // A depth of zero behaves as one; the record is left open here.
    run_phase(depth_t'(0), scale_t'(0), 30, 1'b1);
    // Scale change in the middle of a record, with a gain well beyond one.
    wait_idle();
    write_reg(REG_RECIPROCAL_SCALE, 131071);
    apb_release();
    send_record(12, 1'b1);
    // This phase leaves its record open; the next depth write restarts it.
    run_phase(depth_t'(2), scale_t'(32768), 40, 1'b1);
    while (rand_items < 150) begin
      d = $urandom_range(2, 40);
      run_phase(depth_t'(d),
                scale_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                     : (65536 + d / 2) / d),
                $urandom_range(20, 70), 1'($urandom_range(0, 1)));
    end

    // A long record while the receiver holds off, so that the block has to
    // stall its input.
    wait_idle();
    d = $urandom_range(3, 9);
    write_reg(REG_WINDOW_DEPTH, d);
    write_reg(REG_RECIPROCAL_SCALE, $urandom_range(0, 131071));
    apb_release();
    hold_request = 1'b1;
    send_record(120, 1'b1);

    // Depth above the maximum acts as the maximum; the long record wraps the
    // delay lines.
    wait_idle();
    write_reg(REG_WINDOW_DEPTH, PDATA_BITS'({DEPTH_BITS{1'b1}}));
    write_reg(REG_RECIPROCAL_SCALE, 64);
    apb_release();
    send_record(5, 1'b1);
    send_record(MAX_DEPTH + $urandom_range(0, 6), 1'b1);

    wait_idle();
    write_reg(REG_WINDOW_DEPTH, MAX_DEPTH);
    write_reg(REG_RECIPROCAL_SCALE, 131071);
    apb_release();
    send_record(3, 1'b1);

    wait_idle();
    if (tracker.mismatches == 0 && tracker.expected_averages.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[centered_moving_average.f]
+incdir+sv
sv/cma_pkg.sv
sv/cma_in_if.sv
sv/cma_out_if.sv
sv/cma_regs.sv
sv/cma_front.sv
sv/cma_back.sv
sv/centered_moving_average.sv
sv/cma_checker.sv
sim/testbench.sv
